// ===== rtl/core/sbda_pkg.sv =====
// Types and constants shared by the signed binary to decimal ASCII unit.
`timescale 1ns / 1ps

package sbda_pkg;

  localparam int NUM_POS = 10;
  localparam int IDX_W   = 4;
  localparam int VAL_W   = 32;
  localparam int THR_W   = 34;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  localparam logic [THR_W-1:0] POW10 [NUM_POS] = '{
    34'd1,
    34'd10,
    34'd100,
    34'd1000,
    34'd10000,
    34'd100000,
    34'd1000000,
    34'd10000000,
    34'd100000000,
    34'd1000000000
  };

  typedef struct packed {
    logic             neg;
    logic [VAL_W-1:0] mag;
    logic [IDX_W-1:0] start;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== rtl/core/sbda_front.sv =====
// Front end: takes the signed value apart into sign, magnitude and first digit position.
`timescale 1ns / 1ps

module sbda_front
  import sbda_pkg::*;
(
  input  logic [VAL_W-1:0] value,
  output item_t            item
);

  logic             neg;
  logic [VAL_W-1:0] mag;
  logic [IDX_W-1:0] extra;

  always_comb begin
    neg   = value[VAL_W-1];
    mag   = neg ? (~value + VAL_W'(1)) : value;
    extra = '0;
    for (int k = 1; k < NUM_POS; k++) begin
      if ({{(THR_W-VAL_W){1'b0}}, mag} >= POW10[k]) begin
        extra = extra + IDX_W'(1);
      end
    end
    item.neg   = neg;
    item.mag   = mag;
    item.start = IDX_W'(NUM_POS - 1) - extra;
  end

endmodule

// ===== rtl/core/sbda_queue.sv =====
// Short request queue between the front end and the character sequencer.
`timescale 1ns / 1ps

module sbda_queue
  import sbda_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  item_t         wr_item,
  input  logic          pop,
  output item_t         rd_item,
  output queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign rd_item      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/sbda_back.sv =====
// Back end: emits the sign and one decimal digit per cycle, while the output is not stalled, into an output register.
`timescale 1ns / 1ps

module sbda_back
  import sbda_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  item_t         head,
  input  logic          head_valid,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          out_last
);

  logic             active;
  logic             minus;
  logic [VAL_W-1:0] mag;
  logic [IDX_W-1:0] idx;

  logic [THR_W-1:0] thr [NUM_POS];
  logic [IDX_W-1:0] digit;
  logic [VAL_W-1:0] rem;
  logic [7:0]       cur_char;
  logic             cur_last;
  logic             adv;

  always_comb begin
    for (int k = 0; k < NUM_POS; k++) begin
      thr[k] = '0;
      for (int i = 0; i < NUM_POS; i++) begin
        if (idx == IDX_W'(i)) begin
          thr[k] = THR_W'(k) * POW10[NUM_POS-1-i];
        end
      end
    end
    digit = '0;
    for (int k = 1; k < NUM_POS; k++) begin
      if ({{(THR_W-VAL_W){1'b0}}, mag} >= thr[k]) begin
        digit = digit + IDX_W'(1);
      end
    end
    rem = mag - thr[digit][VAL_W-1:0];
    if (minus) begin
      cur_char = CHAR_MINUS;
      cur_last = 1'b0;
    end else begin
      cur_char = CHAR_ZERO + {4'b0, digit};
      cur_last = (idx == IDX_W'(NUM_POS - 1));
    end
  end

  assign adv = active && (!out_valid || out_ready);
  assign pop = head_valid && (!active || (adv && cur_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
      end else if (adv && cur_last) begin
        active <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      minus <= head.neg;
      mag   <= head.mag;
      idx   <= head.start;
    end else if (adv) begin
      if (minus) begin
        minus <= 1'b0;
      end else begin
        mag <= rem;
        idx <= idx + IDX_W'(1);
      end
    end
    if (adv) begin
      out_char <= cur_char;
      out_last <= cur_last;
    end
  end

endmodule

// ===== rtl/core/signed_binary_to_decimal_ascii_unit.sv =====
// Top level of the signed binary to decimal ASCII unit.
//
//   channel | direction | handshake          | payload
//   s       | in        | s_tvalid/s_tready  | s_tdata[31:0] value (signed)
//   m       | out       | m_tvalid/m_tready  | m_tdata[7:0] ascii_char, m_tlast last_char
//
// One character leaves per cycle while m_tready is held: a number is 1 to 11 characters
// (minus sign plus significant digits), sent by the one-digit-per-cycle sequencer.
// The front end classifies a request in the cycle it is accepted; the queue holds
// QUEUE_DEPTH requests so input keeps flowing while the output stalls.
// Synchronous reset empties the queue and the output register.
// A stalled output holds its character; the sequencer waits with it.
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_unit
  import sbda_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] ascii_char
  output logic        m_tlast
);

  item_t         front_item;
  item_t         head_item;
  queue_status_t qstat;
  logic          push;
  logic          pop;

  assign s_tready = !qstat.full;
  assign push     = s_tvalid && s_tready;

  sbda_front u_front (
    .value (s_tdata),
    .item  (front_item)
  );

  sbda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (front_item),
    .pop     (pop),
    .rd_item (head_item),
    .status  (qstat)
  );

  sbda_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_item),
    .head_valid (!qstat.empty),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_char   (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

// ===== rtl/core/sbda_checker.sv =====
// Port-level checks for the signed binary to decimal ASCII unit, with its bind.
`timescale 1ns / 1ps

module sbda_checker
  import sbda_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output request changed while stalled");

  a_charset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == CHAR_MINUS) ||
                 ((m_tdata >= CHAR_ZERO) && (m_tdata <= CHAR_ZERO + 8'd9)))
    else $error("character outside sign and digit set");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata == CHAR_MINUS) |-> !m_tlast)
    else $error("minus sign closed a run");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind signed_binary_to_decimal_ascii_unit sbda_checker u_sbda_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
